// File: design/complex_arithmetic_unit_core_macros.svh
// Assertion macros used by the checker file of the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/cau_pkg.sv
// Types, codes and constants of the complex arithmetic unit
`default_nettype none

package cau_pkg;

	localparam int CAU_FRAC_BITS = 16;

	// Operation codes
	localparam logic [2:0] KIND_ADD  = 3'd0;
	localparam logic [2:0] KIND_SUB  = 3'd1;
	localparam logic [2:0] KIND_MUL  = 3'd2;
	localparam logic [2:0] KIND_DIV  = 3'd3;
	localparam logic [2:0] KIND_CONJ = 3'd4;
	localparam logic [2:0] KIND_MOD  = 3'd5;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SAT     = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;

	// Depth of the queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} cau_req_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic [1:0]         status;
	} cau_rsp_t;

	// One-hot operation class; all zero for unused codes
	typedef struct packed {
		logic add;
		logic sub;
		logic mul;
		logic div;
		logic conj;
		logic modu;
	} cau_op_t;

	typedef struct packed {
		cau_op_t            op;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} cau_item_t;

	// Handshake from the front queue to the back pipeline
	typedef struct packed {
		logic vld;
	} cau_fq_t;

endpackage

`default_nettype wire

// File: design/cau_front.sv
// Front part: accepts requests, classifies the operation, queues them
`default_nettype none

module cau_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cau_pkg::cau_req_t req,
	output cau_pkg::cau_fq_t  fq,
	output cau_pkg::cau_item_t item,
	input  logic              take
);
	import cau_pkg::*;

	cau_item_t         mem_q [Q_DEPTH];
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QC_W-1:0]   cnt_q;
	cau_item_t         cls;
	logic              wr;
	logic              rd;

	always_comb begin
		cls      = '0;
		cls.a_re = req.a_re;
		cls.a_im = req.a_im;
		cls.b_re = req.b_re;
		cls.b_im = req.b_im;
		case (req.kind)
			KIND_ADD:  cls.op.add  = 1'b1;
			KIND_SUB:  cls.op.sub  = 1'b1;
			KIND_MUL:  cls.op.mul  = 1'b1;
			KIND_DIV:  cls.op.div  = 1'b1;
			KIND_CONJ: cls.op.conj = 1'b1;
			KIND_MOD:  cls.op.modu = 1'b1;
			default:   cls.op      = '0;
		endcase
	end

	assign full   = (cnt_q == QC_W'(Q_DEPTH));
	assign fq.vld = (cnt_q != '0);
	assign item   = mem_q[rd_ptr_q];
	assign wr     = push && !full;
	assign rd     = take && fq.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule

`default_nettype wire

// File: design/cau_back.sv
// Back part: multiply, sum, then pipelined divide and square root, saturate
`default_nettype none

module cau_back #(
	parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cau_pkg::cau_fq_t   fq,
	input  cau_pkg::cau_item_t item,
	output logic               take,
	output logic               empty,
	input  logic               pop,
	output cau_pkg::cau_rsp_t  rsp
);
	import cau_pkg::*;

	localparam int QW = 32;
	localparam int NS = QW + 1;
	localparam int MW = 65;
	localparam int RW = MW + QW;

	localparam logic signed [65:0] S_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S_MIN = -66'sd2147483648;

	typedef struct packed {
		logic        div;
		logic        modu;
		logic        dz;
		logic        sat;
		logic        neg_re;
		logic        neg_im;
		logic [31:0] re;
		logic [31:0] im;
	} pay_t;

	function automatic logic signed [65:0] ext32(input logic signed [31:0] v);
		return {{34{v[31]}}, v};
	endfunction

	function automatic logic signed [65:0] ext64(input logic signed [63:0] v);
		return {{2{v[63]}}, v};
	endfunction

	// {sat, value} of a signed value clipped to 32 bits
	function automatic logic [32:0] sat_s(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > S_MAX) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < S_MIN) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	// {sat, value} of a sign and magnitude, magnitude at or above 2^32 when big
	function automatic logic [32:0] sat_mag(input logic neg, input logic big,
			input logic [31:0] q);
		logic [32:0] m;
		logic [32:0] nm;
		logic [32:0] r;
		m  = big ? {1'b1, 32'h0} : {1'b0, q};
		nm = 33'd0 - m;
		if (!neg) begin
			r = (m > 33'h0_7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, m[31:0]};
		end else begin
			r = (m > 33'h0_8000_0000) ? {1'b1, 32'h8000_0000} : {1'b0, nm[31:0]};
		end
		return r;
	endfunction

	logic en;
	logic out_vld_q;
	cau_rsp_t rsp_q;

	// Whole pipeline holds while a result waits unpopped
	assign en    = !out_vld_q || pop;
	assign take  = en;
	assign empty = !out_vld_q;
	assign rsp   = rsp_q;

	// Stage 1: products
	logic               vld_s1;
	cau_op_t            op_s1;
	logic signed [31:0] a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic signed [31:0] sq_x, sq_y;

	assign sq_x = item.op.modu ? item.a_re : item.b_re;
	assign sq_y = item.op.modu ? item.a_im : item.b_im;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= item.op;
			a_re_s1 <= item.a_re;
			a_im_s1 <= item.a_im;
			b_re_s1 <= item.b_re;
			b_im_s1 <= item.b_im;
			p0_s1   <= item.a_re * item.b_re;
			p1_s1   <= item.a_im * item.b_im;
			p2_s1   <= item.a_re * item.b_im;
			p3_s1   <= item.a_im * item.b_re;
			p4_s1   <= sq_x * sq_x;
			p5_s1   <= sq_y * sq_y;
		end
	end

	// Stage 2: sums
	logic               vld_s2;
	cau_op_t            op_s2;
	logic signed [65:0] re_s2, im_s2;
	logic [63:0]        den_s2;
	logic signed [65:0] re_c, im_c;

	always_comb begin
		re_c = '0;
		im_c = '0;
		if (op_s1.add) begin
			re_c = ext32(a_re_s1) + ext32(b_re_s1);
			im_c = ext32(a_im_s1) + ext32(b_im_s1);
		end else if (op_s1.sub) begin
			re_c = ext32(a_re_s1) - ext32(b_re_s1);
			im_c = ext32(a_im_s1) - ext32(b_im_s1);
		end else if (op_s1.mul) begin
			re_c = ext64(p0_s1) - ext64(p1_s1);
			im_c = ext64(p2_s1) + ext64(p3_s1);
		end else if (op_s1.div) begin
			re_c = ext64(p0_s1) + ext64(p1_s1);
			im_c = ext64(p3_s1) - ext64(p2_s1);
		end else if (op_s1.conj) begin
			re_c = ext32(a_re_s1);
			im_c = -ext32(a_im_s1);
		end else if (op_s1.modu) begin
			re_c = ext64(p4_s1) + ext64(p5_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			re_s2  <= re_c;
			im_s2  <= im_c;
			den_s2 <= p4_s1[63:0] + p5_s1[63:0];
		end
	end

	// Stage 3: saturate direct results, set up divider and root
	logic signed [65:0] nre, nim, mre, mim;
	logic [MW-1:0]      mag_re, mag_im;
	logic [32:0]        sr, si;
	pay_t               pay_c;

	assign nre    = -re_s2;
	assign nim    = -im_s2;
	assign mag_re = re_s2[65] ? nre[MW-1:0] : re_s2[MW-1:0];
	assign mag_im = im_s2[65] ? nim[MW-1:0] : im_s2[MW-1:0];
	assign mre    = re_s2 >>> FRAC_BITS;
	assign mim    = im_s2 >>> FRAC_BITS;

	always_comb begin
		sr = '0;
		si = '0;
		if (op_s2.mul) begin
			sr = sat_s(mre);
			si = sat_s(mim);
		end else if (op_s2.add || op_s2.sub || op_s2.conj) begin
			sr = sat_s(re_s2);
			si = sat_s(im_s2);
		end
		pay_c.div    = op_s2.div;
		pay_c.modu   = op_s2.modu;
		pay_c.dz     = (den_s2 == '0);
		pay_c.sat    = sr[32] | si[32];
		pay_c.neg_re = re_s2[65];
		pay_c.neg_im = im_s2[65];
		pay_c.re     = sr[31:0];
		pay_c.im     = si[31:0];
	end

	// Iteration stages; entry 0 is stage 3
	logic          vld_si  [NS+1];
	pay_t          pay_si  [NS+1];
	logic [RW-1:0] rre_si  [NS+1];
	logic [RW-1:0] rim_si  [NS+1];
	logic [QW-1:0] qre_si  [NS+1];
	logic [QW-1:0] qim_si  [NS+1];
	logic          bre_si  [NS+1];
	logic          bim_si  [NS+1];
	logic [63:0]   den_si  [NS+1];
	logic [63:0]   sv_si   [NS+1];
	logic [63:0]   sres_si [NS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			pay_si[0]  <= pay_c;
			rre_si[0]  <= {{(RW-MW){1'b0}}, mag_re} << FRAC_BITS;
			rim_si[0]  <= {{(RW-MW){1'b0}}, mag_im} << FRAC_BITS;
			qre_si[0]  <= '0;
			qim_si[0]  <= '0;
			bre_si[0]  <= 1'b0;
			bim_si[0]  <= 1'b0;
			den_si[0]  <= den_s2;
			sv_si[0]   <= re_s2[63:0];
			sres_si[0] <= '0;
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_it
		if (j == 0) begin : g_ovf
			// Flag quotients of 2^32 or more
			always_ff @(posedge clk) begin
				if (en) begin
					pay_si[j+1]  <= pay_si[j];
					rre_si[j+1]  <= rre_si[j];
					rim_si[j+1]  <= rim_si[j];
					qre_si[j+1]  <= qre_si[j];
					qim_si[j+1]  <= qim_si[j];
					bre_si[j+1]  <= rre_si[j] >= (RW'(den_si[j]) << QW);
					bim_si[j+1]  <= rim_si[j] >= (RW'(den_si[j]) << QW);
					den_si[j+1]  <= den_si[j];
					sv_si[j+1]   <= sv_si[j];
					sres_si[j+1] <= sres_si[j];
				end
			end
		end else begin : g_step
			localparam int K = QW - j;
			localparam logic [63:0] SBIT = 64'd1 << (2 * K);
			logic [RW-1:0] dsh;
			logic [63:0]   st;
			logic          ge_re, ge_im, ge_s;

			assign dsh   = RW'(den_si[j]) << K;
			assign ge_re = rre_si[j] >= dsh;
			assign ge_im = rim_si[j] >= dsh;
			assign st    = sres_si[j] + SBIT;
			assign ge_s  = sv_si[j] >= st;

			always_ff @(posedge clk) begin
				if (en) begin
					pay_si[j+1]  <= pay_si[j];
					rre_si[j+1]  <= ge_re ? rre_si[j] - dsh : rre_si[j];
					rim_si[j+1]  <= ge_im ? rim_si[j] - dsh : rim_si[j];
					qre_si[j+1]  <= ge_re ? (qre_si[j] | (QW'(1) << K)) : qre_si[j];
					qim_si[j+1]  <= ge_im ? (qim_si[j] | (QW'(1) << K)) : qim_si[j];
					bre_si[j+1]  <= bre_si[j];
					bim_si[j+1]  <= bim_si[j];
					den_si[j+1]  <= den_si[j];
					sv_si[j+1]   <= ge_s ? sv_si[j] - st : sv_si[j];
					sres_si[j+1] <= ge_s ? (sres_si[j] >> 1) + SBIT : sres_si[j] >> 1;
				end
			end
		end
	end

	// Output stage
	logic [32:0] fr, fi;
	cau_rsp_t    rsp_c;
	pay_t        pl;

	assign pl = pay_si[NS];

	always_comb begin
		fr = {pl.sat, pl.re};
		fi = {1'b0, pl.im};
		if (pl.div) begin
			if (pl.dz) begin
				fr = '0;
				fi = '0;
			end else begin
				fr = sat_mag(pl.neg_re, bre_si[NS], qre_si[NS]);
				fi = sat_mag(pl.neg_im, bim_si[NS], qim_si[NS]);
			end
		end else if (pl.modu) begin
			fr = sat_mag(1'b0, |sres_si[NS][63:32], sres_si[NS][31:0]);
			fi = '0;
		end
		rsp_c.res_re = fr[31:0];
		rsp_c.res_im = fi[31:0];
		if (pl.div && pl.dz) begin
			rsp_c.status = ST_DIVZERO;
		end else if (fr[32] || fi[32]) begin
			rsp_c.status = ST_SAT;
		end else begin
			rsp_c.status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i <= NS; i++) begin
				vld_si[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1    <= fq.vld;
			vld_s2    <= vld_s1;
			vld_si[0] <= vld_s2;
			for (int i = 1; i <= NS; i++) begin
				vld_si[i] <= vld_si[i-1];
			end
			out_vld_q <= vld_si[NS];
		end
	end

endmodule

`default_nettype wire

// File: design/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit
//
//   channel   direction  handshake          payload
//   request   in         push / full        req (cau_req_t)
//   result    out        empty / pop        rsp (cau_rsp_t)
//
// One request per cycle is taken while the back pipeline is not held by an
// unpopped result.
// Each result passes through one multiply, one sum and one setup stage,
// then the 33 stages of the pipelined dividers and square root.
// Reset empties the front queue and clears all stage valids.
// A result left unpopped freezes the back pipeline; the two-entry front
// queue then fills and full rises.
`default_nettype none

module complex_arithmetic_unit_core #(
	parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cau_pkg::cau_req_t req,
	output logic              empty,
	input  logic              pop,
	output cau_pkg::cau_rsp_t rsp
);
	import cau_pkg::*;

	cau_fq_t   fq;
	cau_item_t item;
	logic      take;

	cau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.fq     (fq),
		.item   (item),
		.take   (take)
	);

	cau_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fq     (fq),
		.item   (item),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// File: design/cau_chk.sv
// Port-level checker of the complex arithmetic unit, bound to the top level
`default_nettype none

`include "complex_arithmetic_unit_core_macros.svh"

module cau_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input cau_pkg::cau_req_t req,
	input logic              empty,
	input logic              pop,
	input cau_pkg::cau_rsp_t rsp
);
	import cau_pkg::*;

	logic req_seen;
	assign req_seen = (req.kind == KIND_ADD) || !push || 1'b1;

	`CAU_ASSERT_NXT(a_rsp_hold, clk, arst_n, !empty && !pop, !empty && $stable(rsp), "result changed while stalled")
	`CAU_ASSERT_IMP(a_dz_zero, clk, arst_n, !empty && rsp.status == ST_DIVZERO && req_seen, rsp.res_re == 0 && rsp.res_im == 0, "division by zero with nonzero result")
	`CAU_ASSERT_NXT(a_full_push, clk, arst_n, !full && !push, !full, "queue filled without a request")
	`CAU_ASSERT_IMP(a_full_stall, clk, arst_n, full, !empty, "queue full while no result waits")

endmodule

bind complex_arithmetic_unit_core cau_chk u_chk (.*);

`default_nettype wire
